>>> hw/rtl/cst_pkg.sv
`default_nettype none
package cst_pkg;
   localparam int USER_SEMS  = 8;
   localparam int TOTAL_SEMS = 16;
   localparam int WAIT_DEPTH = 16;
   localparam int SEM_W  = 4;
   localparam int POS_W  = $clog2(WAIT_DEPTH);
   localparam int LEN_W  = $clog2(WAIT_DEPTH + 1);
   localparam int ADDR_W = $clog2(TOTAL_SEMS * WAIT_DEPTH);
   localparam int QDEPTH = 2;

   localparam logic [2:0] OP_OPEN  = 3'd0;
   localparam logic [2:0] OP_FIRST = 3'd1;
   localparam logic [2:0] OP_WAIT  = 3'd2;
   localparam logic [2:0] OP_POST  = 3'd3;
   localparam logic [2:0] OP_POSTZ = 3'd4;
   localparam logic [2:0] OP_CLOSE = 3'd5;
   localparam logic [2:0] OP_REMOVE = 3'd6;
   localparam logic [2:0] OP_NONE  = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_NOT_OPEN  = 3'd2;
   localparam logic [2:0] ST_QFULL     = 3'd3;
   localparam logic [2:0] ST_NONE_FREE = 3'd4;
   localparam logic [2:0] ST_REFS_FULL = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  sem_id;
      logic        id_valid;
      logic [15:0] initial_value;
      logic [7:0]  waiter_id;
   } cmd_type;
endpackage
`default_nettype wire

>>> hw/rtl/cst_front.sv
`default_nettype none
module cst_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [2:0]       req_operation,
   input  wire logic [3:0]       req_sem_id,
   input  wire logic             req_kernel_space,
   input  wire logic [15:0]      req_initial_value,
   input  wire logic [7:0]       req_waiter_id,
   output logic                  q_valid,
   output cst_pkg::cmd_type      q_cmd,
   input  wire logic             q_pop
);
   cst_pkg::cmd_type q_ff [cst_pkg::QDEPTH];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, ok;

   assign busy = (cnt_ff == 2'(cst_pkg::QDEPTH));
   assign push = start && !busy;

   always_comb begin
      ok = 32'(req_sem_id) < cst_pkg::TOTAL_SEMS;
      if (req_operation != cst_pkg::OP_REMOVE) begin
         if (req_kernel_space) ok = ok && 32'(req_sem_id) >= cst_pkg::USER_SEMS;
         else ok = ok && 32'(req_sem_id) < cst_pkg::USER_SEMS;
      end
   end

   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd   = q_ff[rd_ff];
   assign wr_in   = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in   = q_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in  = cnt_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{req_operation, req_sem_id, ok, req_initial_value, req_waiter_id};
      end
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/cst_back.sv
`default_nettype none
module cst_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire cst_pkg::cmd_type q_cmd,
   output logic                 q_pop,
   output logic                 rsp_strobe,
   output logic [2:0]           rsp_status,
   output logic [3:0]           rsp_granted_id,
   output logic                 rsp_caller_blocks,
   output logic                 rsp_woken_valid,
   output logic [7:0]           rsp_woken_id,
   output logic                 rsp_last
);
   localparam int TS = cst_pkg::TOTAL_SEMS;
   localparam int PW = cst_pkg::POS_W;
   localparam int LW = cst_pkg::LEN_W;
   localparam int AW = cst_pkg::ADDR_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_POP   = 6'b000100,
      S_POPO  = 6'b001000,
      S_RMRD  = 6'b010000,
      S_RMCHK = 6'b100000
   } state_type;

   state_type   st_ff, st_in;
   logic [15:0] cnt_ff [TS];
   logic [7:0]  refs_ff [TS];
   logic [PW-1:0] head_ff [TS];
   logic [LW-1:0] len_ff [TS];
   logic [7:0]  mem [TS * cst_pkg::WAIT_DEPTH];
   logic [7:0]  rd_ff;
   cst_pkg::cmd_type c_ff;
   logic [LW-1:0] i_ff;
   logic        found_ff;
   logic [3:0]  s;
   logic [7:0]  s_refs;
   logic [15:0] s_cnt;
   logic [PW-1:0] s_head;
   logic [LW-1:0] s_len;
   logic        mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]  mem_wd;
   logic [3:0]  free_id;
   logic        free_ok;

   assign s      = c_ff.sem_id;
   assign s_refs = refs_ff[s];
   assign s_cnt  = cnt_ff[s];
   assign s_head = head_ff[s];
   assign s_len  = len_ff[s];

   function automatic logic [AW-1:0] slot(input logic [3:0] sm, input logic [LW-1:0] p);
      logic [AW-1:0] b;
      b = AW'(32'(sm) * cst_pkg::WAIT_DEPTH);
      return b + AW'(p[PW-1:0]);
   endfunction

   always_comb begin
      free_ok = 1'b0; free_id = '0;
      for (int k = cst_pkg::USER_SEMS - 1; k >= 0; k--) begin
         if (k < TS && k < 16 && refs_ff[k] == 8'd0) begin
            free_ok = 1'b1; free_id = 4'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   always_comb begin
      st_in = st_ff; q_pop = 1'b0;
      mem_we = 1'b0; mem_wa = '0; mem_wd = c_ff.waiter_id;
      mem_re = 1'b0; mem_ra = slot(s, LW'(s_head) + i_ff);
      case (st_ff)
         S_IDLE: if (q_valid) begin q_pop = 1'b1; st_in = S_EXEC; end
         S_EXEC: begin
            st_in = S_IDLE;
            if (c_ff.operation == cst_pkg::OP_REMOVE) begin
               if (c_ff.id_valid && s_len != '0) begin
                  mem_re = 1'b1; st_in = S_RMRD;
               end
            end else if (c_ff.operation inside {cst_pkg::OP_WAIT, cst_pkg::OP_POST,
                         cst_pkg::OP_POSTZ, cst_pkg::OP_CLOSE} && c_ff.id_valid &&
                         s_refs != 8'd0) begin
               case (c_ff.operation)
                  cst_pkg::OP_WAIT: if (s_cnt == 16'd0 && 32'(s_len) < cst_pkg::WAIT_DEPTH) begin
                     mem_we = 1'b1; mem_wa = slot(s, LW'(s_head) + s_len);
                  end
                  cst_pkg::OP_POST, cst_pkg::OP_POSTZ:
                     if ((c_ff.operation == cst_pkg::OP_POST || s_cnt == 16'd0) && s_len != '0) begin
                        mem_re = 1'b1; mem_ra = slot(s, LW'(s_head)); st_in = S_POPO;
                     end
                  cst_pkg::OP_CLOSE: if (s_refs == 8'd1 && s_len != '0) begin
                     mem_re = 1'b1; mem_ra = slot(s, LW'(s_head)); st_in = S_POP;
                  end
                  default: ;
               endcase
            end
         end
         S_POPO: st_in = S_IDLE;
         S_POP: begin
            if (s_len > LW'(1)) begin
               mem_re = 1'b1; mem_ra = slot(s, LW'(s_head) + LW'(1));
            end else st_in = S_IDLE;
         end
         S_RMRD: st_in = S_RMCHK;
         S_RMCHK: begin
            // found: shift entry i down to i-1; else compare
            if (found_ff || rd_ff == c_ff.waiter_id) begin
               if (found_ff) begin
                  mem_we = 1'b1; mem_wa = slot(s, LW'(s_head) + i_ff - LW'(1)); mem_wd = rd_ff;
               end
            end
            if (i_ff + LW'(1) < s_len) begin
               mem_re = 1'b1; mem_ra = slot(s, LW'(s_head) + i_ff + LW'(1)); st_in = S_RMRD;
            end else st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_strobe <= 1'b0;
      rsp_status <= cst_pkg::ST_OK; rsp_granted_id <= '0; rsp_caller_blocks <= 1'b0;
      rsp_woken_valid <= 1'b0; rsp_woken_id <= '0; rsp_last <= 1'b1;
      if (st_ff == S_IDLE && q_valid) begin
         c_ff <= q_cmd; i_ff <= '0; found_ff <= 1'b0;
      end
      case (st_ff)
         S_EXEC: begin
            if (c_ff.operation == cst_pkg::OP_FIRST) begin
               rsp_strobe <= 1'b1;
               if (free_ok) begin
                  rsp_granted_id <= free_id;
                  refs_ff[free_id] <= 8'd1; cnt_ff[free_id] <= c_ff.initial_value;
                  head_ff[free_id] <= '0; len_ff[free_id] <= '0;
               end else rsp_status <= cst_pkg::ST_NONE_FREE;
            end else if (c_ff.operation == cst_pkg::OP_REMOVE) begin
               if (!c_ff.id_valid) begin
                  rsp_strobe <= 1'b1; rsp_status <= cst_pkg::ST_INVALID;
               end else if (s_len == '0) rsp_strobe <= 1'b1;
            end else if (c_ff.operation == cst_pkg::OP_NONE) begin
               rsp_strobe <= 1'b1;
            end else if (!c_ff.id_valid) begin
               rsp_strobe <= 1'b1; rsp_status <= cst_pkg::ST_INVALID;
            end else if (c_ff.operation == cst_pkg::OP_OPEN) begin
               rsp_strobe <= 1'b1;
               if (s_refs != 8'd0) begin
                  if (s_refs == 8'hFF) rsp_status <= cst_pkg::ST_REFS_FULL;
                  else refs_ff[s] <= s_refs + 8'd1;
               end else begin
                  refs_ff[s] <= 8'd1; cnt_ff[s] <= c_ff.initial_value;
                  head_ff[s] <= '0; len_ff[s] <= '0;
               end
            end else if (s_refs == 8'd0) begin
               rsp_strobe <= 1'b1; rsp_status <= cst_pkg::ST_NOT_OPEN;
            end else begin
               case (c_ff.operation)
                  cst_pkg::OP_WAIT: begin
                     rsp_strobe <= 1'b1;
                     if (s_cnt != 16'd0) cnt_ff[s] <= s_cnt - 16'd1;
                     else if (32'(s_len) >= cst_pkg::WAIT_DEPTH) rsp_status <= cst_pkg::ST_QFULL;
                     else begin
                        len_ff[s] <= s_len + LW'(1); rsp_caller_blocks <= 1'b1;
                     end
                  end
                  cst_pkg::OP_POST, cst_pkg::OP_POSTZ: begin
                     if (c_ff.operation == cst_pkg::OP_POST || s_cnt == 16'd0) begin
                        if (s_len == '0) begin
                           rsp_strobe <= 1'b1;
                           if (s_cnt != 16'hFFFF) cnt_ff[s] <= s_cnt + 16'd1;
                        end
                     end else rsp_strobe <= 1'b1;
                  end
                  default: begin
                     refs_ff[s] <= s_refs - 8'd1;
                     if (!(s_refs == 8'd1 && s_len != '0)) rsp_strobe <= 1'b1;
                  end
               endcase
            end
         end
         S_POPO, S_POP: begin
            rsp_strobe <= 1'b1; rsp_woken_valid <= 1'b1; rsp_woken_id <= rd_ff;
            len_ff[s] <= s_len - LW'(1);
            head_ff[s] <= s_head + PW'(1);
            if (st_ff == S_POP) begin
               rsp_last <= (s_len == LW'(1));
               if (s_len == LW'(1)) head_ff[s] <= '0;
            end
         end
         S_RMCHK: begin
            if (!found_ff && rd_ff == c_ff.waiter_id) found_ff <= 1'b1;
            i_ff <= i_ff + LW'(1);
            if (!(i_ff + LW'(1) < s_len)) begin
               rsp_strobe <= 1'b1;
               if (found_ff || rd_ff == c_ff.waiter_id) len_ff[s] <= s_len - LW'(1);
            end
         end
         default: ;
      endcase
      if (reset) begin
         st_ff <= S_IDLE; rsp_strobe <= 1'b0;
         for (int k = 0; k < TS; k++) begin
            cnt_ff[k] <= '0; refs_ff[k] <= '0; head_ff[k] <= '0; len_ff[k] <= '0;
         end
      end else st_ff <= st_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/counting_semaphore_table.sv
`default_nettype none
// Table of counting semaphores with per-semaphore waiter FIFOs. Commands enter a two-deep
// queue; busy is high only when it is full. The execution unit takes a command from the queue
// only when idle, then executes it; a post that wakes a waiter adds a pop step, a last close
// pops its waiters one at a time, and a remove walks the queued entries with a read step,
// then a compare-and-shift step, per entry. Results appear for exactly one cycle on
// rsp_strobe and cannot be held off; rsp_last marks the final beat.
module counting_semaphore_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [3:0]  req_sem_id,
   input  wire logic        req_kernel_space,
   input  wire logic [15:0] req_initial_value,
   input  wire logic [7:0]  req_waiter_id,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_granted_id,
   output logic             rsp_caller_blocks,
   output logic             rsp_woken_valid,
   output logic [7:0]       rsp_woken_id,
   output logic             rsp_last
);
   logic             q_valid, q_pop;
   cst_pkg::cmd_type q_cmd;

   cst_front u_front (.clock, .reset, .start, .busy, .req_operation, .req_sem_id,
      .req_kernel_space, .req_initial_value, .req_waiter_id, .q_valid, .q_cmd, .q_pop);

   cst_back u_back (.clock, .reset, .q_valid, .q_cmd, .q_pop, .rsp_strobe, .rsp_status,
      .rsp_granted_id, .rsp_caller_blocks, .rsp_woken_valid, .rsp_woken_id, .rsp_last);
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
import cst_pkg::*;

typedef struct {
   logic [2:0] status;
   logic [3:0] granted_id;
   logic       caller_blocks;
   logic       woken_valid;
   logic [7:0] woken_id;
   logic       last;
} sem_beat_type;

class sem_scoreboard;
   logic [15:0] units [TOTAL_SEMS];
   logic [7:0]  refs [TOTAL_SEMS];
   logic [7:0]  waiters [TOTAL_SEMS][$];
   sem_beat_type pending [$];
   int          errors;
   int          beats;

   function new();
      errors = 0;
      beats = 0;
      foreach (units[i]) begin
         units[i] = '0;
         refs[i] = '0;
      end
   endfunction

   function void push(logic [2:0] st, logic [3:0] gid, logic blk, logic wv,
                      logic [7:0] wid, logic lst);
      sem_beat_type b;
      b.status = st;
      b.granted_id = gid;
      b.caller_blocks = blk;
      b.woken_valid = wv;
      b.woken_id = wid;
      b.last = lst;
      pending.push_back(b);
   endfunction

   function logic [2:0] do_open(int s, logic [15:0] init);
      if (refs[s] != 0) begin
         if (refs[s] == 8'hFF) return ST_REFS_FULL;
         refs[s]++;
         return ST_OK;
      end
      refs[s] = 1;
      units[s] = init;
      waiters[s].delete();
      return ST_OK;
   endfunction

   function void note_cmd(logic [2:0] op, logic [3:0] s, logic k, logic [15:0] init,
                          logic [7:0] wid);
      bit ok;
      bit done;
      logic [2:0] st;
      int n;
      ok = (s < TOTAL_SEMS) && (k ? (s >= USER_SEMS) : (s < USER_SEMS));
      done = 0;
      if (op == OP_FIRST) begin
         for (int i = 0; i < USER_SEMS && i < TOTAL_SEMS && i < 16; i++)
            if (!done && refs[i] == 0) begin
               st = do_open(i, init);
               push(ST_OK, i[3:0], 0, 0, 0, 1);
               done = 1;
            end
         if (!done) push(ST_NONE_FREE, 0, 0, 0, 0, 1);
      end else if (op == OP_REMOVE) begin
         for (int i = 0; i < waiters[s].size(); i++)
            if (!done && waiters[s][i] == wid) begin
               waiters[s].delete(i);
               done = 1;
            end
         push(ST_OK, 0, 0, 0, 0, 1);
      end else if (op == OP_NONE) begin
         push(ST_OK, 0, 0, 0, 0, 1);
      end else if (!ok) begin
         push(ST_INVALID, 0, 0, 0, 0, 1);
      end else if (op == OP_OPEN) begin
         push(do_open(s, init), 0, 0, 0, 0, 1);
      end else if (refs[s] == 0) begin
         push(ST_NOT_OPEN, 0, 0, 0, 0, 1);
      end else if (op == OP_WAIT) begin
         if (units[s] > 0) begin
            units[s]--;
            push(ST_OK, 0, 0, 0, 0, 1);
         end else if (waiters[s].size() >= WAIT_DEPTH) begin
            push(ST_QFULL, 0, 0, 0, 0, 1);
         end else begin
            waiters[s].push_back(wid);
            push(ST_OK, 0, 1, 0, 0, 1);
         end
      end else if (op == OP_POST || op == OP_POSTZ) begin
         if (op == OP_POST || units[s] == 0) begin
            if (waiters[s].size() == 0) begin
               if (units[s] != 16'hFFFF) units[s]++;
            end else begin
               push(ST_OK, 0, 0, 1, waiters[s].pop_front(), 1);
               done = 1;
            end
         end
         if (!done) push(ST_OK, 0, 0, 0, 0, 1);
      end else begin
         refs[s]--;
         if (refs[s] == 0 && waiters[s].size() > 0) begin
            n = waiters[s].size();
            for (int i = 0; i < n; i++)
               push(ST_OK, 0, 0, 1, waiters[s].pop_front(), i == n - 1);
         end else
            push(ST_OK, 0, 0, 0, 0, 1);
      end
   endfunction

   task automatic check_beat(sem_beat_type got);
      sem_beat_type exp_b;
      beats++;
      if (pending.size() == 0) begin
         report_err("result beat with nothing pending");
         return;
      end
      exp_b = pending.pop_front();
      if (got.status !== exp_b.status) report_err("status mismatch");
      if (got.granted_id !== exp_b.granted_id) report_err("granted_id mismatch");
      if (got.caller_blocks !== exp_b.caller_blocks) report_err("caller_blocks mismatch");
      if (got.woken_valid !== exp_b.woken_valid) report_err("woken_valid mismatch");
      if (got.woken_id !== exp_b.woken_id) report_err("woken_id mismatch");
      if (got.last !== exp_b.last) report_err("last mismatch");
   endtask

   task automatic report_err(string msg);
      errors++;
      if (errors <= 50) $display("%0t mismatch: %s", $realtime, msg);
   endtask
endclass

module tb_top;
   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_operation;
   logic [3:0]  req_sem_id;
   logic        req_kernel_space;
   logic [15:0] req_initial_value;
   logic [7:0]  req_waiter_id;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_granted_id;
   logic        rsp_caller_blocks;
   logic        rsp_woken_valid;
   logic [7:0]  rsp_woken_id;
   logic        rsp_last;

   sem_scoreboard sem_sb;
   int          cycles;
   int          sent;

   counting_semaphore_table u_top (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      sem_beat_type b;
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         b.status = rsp_status;
         b.granted_id = rsp_granted_id;
         b.caller_blocks = rsp_caller_blocks;
         b.woken_valid = rsp_woken_valid;
         b.woken_id = rsp_woken_id;
         b.last = rsp_last;
         sem_sb.check_beat(b);
      end
      if (cycles > 400000) begin
         $display("timeout");
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_cmd(logic [2:0] op, logic [3:0] s, logic k, logic [15:0] init,
                           logic [7:0] wid);
      start = 1;
      req_operation = op;
      req_sem_id = s;
      req_kernel_space = k;
      req_initial_value = init;
      req_waiter_id = wid;
      @(posedge clock);
      while (busy) @(posedge clock);
      sem_sb.note_cmd(op, s, k, init, wid);
      sent++;
      @(negedge clock);
      start = 0;
   endtask

   task automatic send_rand(int focus);
      logic [2:0] op;
      logic [3:0] s;
      logic       k;
      op = 3'($urandom_range(0, 7));
      if (focus) begin
         s = (op == OP_REMOVE || $urandom_range(0, 7) == 0) ? 4'($urandom)
                                                            : 4'($urandom_range(0, 3));
         k = 0;
         if ($urandom_range(0, 5) == 0) begin
            s = 4'($urandom_range(USER_SEMS, USER_SEMS + 3));
            k = 1;
         end
         if ($urandom_range(0, 9) == 0) k = ~k;
      end else begin
         s = 4'($urandom);
         k = 1'($urandom);
      end
      send_cmd(op, s, k,
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2)),
               $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom));
   endtask

   task automatic drain();
      while (sem_sb.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   initial begin
      sem_sb = new();
      cycles = 0;
      sent = 0;
      reset = 1;
      start = 0;
      req_operation = OP_OPEN;
      req_sem_id = 0;
      req_kernel_space = 0;
      req_initial_value = 0;
      req_waiter_id = 0;
      repeat (5) @(negedge clock);
      reset = 0;
      @(negedge clock);

      send_cmd(OP_WAIT, 3, 0, 0, 0);
      send_cmd(OP_OPEN, 9, 0, 0, 0);
      send_cmd(OP_OPEN, 3, 1, 0, 0);
      send_cmd(OP_OPEN, 15, 1, 16'hFFFF, 0);
      send_cmd(OP_POST, 15, 1, 0, 0);
      send_cmd(OP_POSTZ, 15, 1, 0, 0);
      send_cmd(OP_OPEN, 2, 0, 0, 0);
      send_cmd(OP_OPEN, 2, 0, 16'h1234, 0);
      send_cmd(OP_WAIT, 2, 0, 0, 8'hFF);
      send_cmd(OP_WAIT, 2, 0, 0, 8'h00);
      send_cmd(OP_WAIT, 2, 0, 0, 8'hA5);
      send_cmd(OP_REMOVE, 2, 1, 0, 8'h00);
      send_cmd(OP_REMOVE, 2, 0, 0, 8'h77);
      send_cmd(OP_POST, 2, 0, 0, 0);
      send_cmd(OP_NONE, 5, 1, 16'hFFFF, 8'hFF);
      send_cmd(OP_FIRST, 0, 0, 16'h5A5A, 0);
      send_cmd(OP_CLOSE, 2, 0, 0, 0);
      send_cmd(OP_CLOSE, 2, 0, 0, 0);
      send_cmd(OP_POSTZ, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++) send_cmd(OP_FIRST, 0, 0, 1, 0);
      drain();
      // fill one queue past depth, then close releases the whole FIFO
      send_cmd(OP_OPEN, 12, 1, 0, 0);
      for (int i = 0; i < WAIT_DEPTH + 2; i++) send_cmd(OP_WAIT, 12, 1, 0, 8'(i * 13));
      send_cmd(OP_CLOSE, 12, 1, 0, 0);
      // saturate the reference count
      send_cmd(OP_OPEN, 13, 1, 0, 0);
      for (int i = 0; i < 256; i++) begin
         send_cmd(OP_OPEN, 13, 1, 0, 0);
      end
      drain();
      for (int i = 0; i < 8; i++) begin
         send_cmd(OP_CLOSE, 4'(i), 0, 0, 0);
         send_cmd(OP_CLOSE, 4'(i), 0, 0, 0);
      end

      for (int i = 0; i < 100; i++) begin
         idle_gap();
         send_rand(i % 10 != 0);
         if (i == 50) drain();
      end
      drain();

      $display("sent %0d commands, checked %0d result beats", sent, sem_sb.beats);
      if (sem_sb.errors == 0 && sem_sb.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
